// ===== design/glg_pkg.sv =====
// Shared types, constants and helper functions of the Gaussian line evaluator.
package glg_pkg;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  // Sideband that travels with an item through the first divider and the shape unit.
  typedef struct packed {
    logic [31:0] amp_mag;
    logic        amp_neg;
    logic        dist_neg;
    logic [30:0] width;
  } glg_side_t;

  // 2^(-t) for t in Q0.32, from the series of exp(-t*ln2) up to the 14th power, rounded to Q0.16.
  function automatic logic [16:0] frac_entry(input logic [63:0] t);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    r = (t * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    sum = 64'd1 << 32;
    term = (term * r) >> 32;           sum = sum - term;
    term = ((term * r) >> 32) / 64'd2;  sum = sum + term;
    term = ((term * r) >> 32) / 64'd3;  sum = sum - term;
    term = ((term * r) >> 32) / 64'd4;  sum = sum + term;
    term = ((term * r) >> 32) / 64'd5;  sum = sum - term;
    term = ((term * r) >> 32) / 64'd6;  sum = sum + term;
    term = ((term * r) >> 32) / 64'd7;  sum = sum - term;
    term = ((term * r) >> 32) / 64'd8;  sum = sum + term;
    term = ((term * r) >> 32) / 64'd9;  sum = sum - term;
    term = ((term * r) >> 32) / 64'd10; sum = sum + term;
    term = ((term * r) >> 32) / 64'd11; sum = sum - term;
    term = ((term * r) >> 32) / 64'd12; sum = sum + term;
    term = ((term * r) >> 32) / 64'd13; sum = sum - term;
    term = ((term * r) >> 32) / 64'd14; sum = sum + term;
    return 17'((sum + 64'd32768) >> 16);
  endfunction

  // Signed 32-bit saturation of a magnitude; ovf marks a magnitude of 2^32 or more.
  function automatic logic [31:0] sat32(input logic neg, input logic ovf,
                                        input logic [31:0] mag);
    logic [31:0] res;
    if (ovf) begin
      res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!neg) begin
      res = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
    end else begin
      res = (mag > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag);
    end
    return res;
  endfunction

endpackage

// ===== design/glg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module glg_div #(
  parameter int NUM_W  = 50,
  parameter int DEN_W  = 31,
  parameter int Q_W    = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int CW = (NUM_W > DEN_W + Q_W + 1) ? NUM_W : DEN_W + Q_W + 1;

  logic [Q_W:0]        vld_r;
  logic [NUM_W-1:0]    rem_r  [Q_W+1];
  logic [DEN_W-1:0]    den_r  [Q_W+1];
  logic [Q_W:0]        quo_r  [Q_W+1];
  logic [SIDE_W-1:0]   side_r [Q_W+1];

  // Stage j decides quotient bit Q_W-j; the top bit doubles as the overflow flag.
  for (genvar j = 0; j <= Q_W; j++) begin : g_stage
    localparam int B = Q_W - j;
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W:0]      quo_in;
    logic [SIDE_W-1:0] side_s;
    logic [CW-1:0]     sub_d;
    logic              ge;
    logic [NUM_W-1:0]  rem_nxt;
    logic [Q_W:0]      quo_nxt;

    if (j == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign side_s = side_in;
    end else begin : g_next
      assign vld_in = vld_r[j-1];
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
      assign side_s = side_r[j-1];
    end

    assign sub_d   = CW'(den_in) << B;
    assign ge      = CW'(rem_in) >= sub_d;
    assign rem_nxt = ge ? NUM_W'(CW'(rem_in) - sub_d) : rem_in;
    assign quo_nxt = quo_in | ((Q_W+1)'(ge) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        quo_r[j]  <= quo_nxt;
        side_r[j] <= side_s;
      end
    end
  end

  assign out_valid = vld_r[Q_W];
  assign quot      = quo_r[Q_W][Q_W-1:0];
  assign ovf       = quo_r[Q_W][Q_W];
  assign side_out  = side_r[Q_W];

endmodule

// ===== design/glg_shape.sv =====
// Shape unit: squares xl, looks up the fraction table and applies the integer shift.
module glg_shape #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int SIDE_W          = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [23:0]       xlm,
  input  logic              xlm_ovf,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [16:0]       shape,
  output logic [18:0]       xlm_z,
  output logic [20:0]       q_z,
  output logic [SIDE_W-1:0] side_out
);
  import glg_pkg::*;

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

  logic [16:0] rom [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] T_K = (64'(k) << 32) / EXP_TABLE_DEPTH;
    assign rom[k] = frac_entry(T_K);
  end

  // Stage 1: square and round xl.
  logic              v1_r, ok1_r;
  logic [31:0]       q1_r;
  logic [18:0]       xlm1_r;
  logic [SIDE_W-1:0] side1_r;
  logic [47:0]       sq;
  logic [31:0]       q1_nxt;

  assign sq     = 48'(xlm) * 48'(xlm);
  assign q1_nxt = 32'((sq + 48'd32768) >> 16);

  // Stage 2: table read.
  logic              v2_r, ok2_r;
  logic [16:0]       ent2_r;
  logic [4:0]        n2_r;
  logic [18:0]       xlm2_r;
  logic [20:0]       q2_r;
  logic [SIDE_W-1:0] side2_r;
  logic [16+IDX_W:0] idx_prod;
  logic [IDX_W-1:0]  idx;
  logic              ok2_nxt;

  assign idx_prod = (17+IDX_W)'(q1_r[15:0]) * (17+IDX_W)'(EXP_TABLE_DEPTH);
  assign idx      = idx_prod[16 +: IDX_W];
  assign ok2_nxt  = ok1_r && (q1_r[31:16] < 16'd17);

  // Stage 3: shift by the integer part with rounding.
  logic              v3_r;
  logic [16:0]       shape3_r;
  logic [18:0]       xlm3_r;
  logic [20:0]       q3_r;
  logic [SIDE_W-1:0] side3_r;
  logic [17:0]       e_rnd;
  logic [16:0]       shp;
  logic [16:0]       shape_nxt;

  assign e_rnd     = {1'b0, ent2_r} + ((n2_r == 5'd0) ? 18'd0 : (18'd1 << (n2_r - 5'd1)));
  assign shp       = 17'(e_rnd >> n2_r);
  assign shape_nxt = ok2_r ? shp : 17'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r     <= q1_nxt;
      xlm1_r   <= xlm[18:0];
      ok1_r    <= !xlm_ovf;
      side1_r  <= side_in;
      ent2_r   <= rom[idx];
      n2_r     <= q1_r[20:16];
      xlm2_r   <= xlm1_r;
      q2_r     <= q1_r[20:0];
      ok2_r    <= ok2_nxt;
      side2_r  <= side1_r;
      shape3_r <= shape_nxt;
      xlm3_r   <= (shape_nxt != 17'd0) ? xlm2_r : 19'd0;
      q3_r     <= (shape_nxt != 17'd0) ? q2_r : 21'd0;
      side3_r  <= side2_r;
    end
  end

  assign out_valid = v3_r;
  assign shape     = shape3_r;
  assign xlm_z     = xlm3_r;
  assign q_z       = q3_r;
  assign side_out  = side3_r;

endmodule

// ===== design/gaussian_line_with_gradient.sv =====
// Top level of the Gaussian line evaluator with its parameter gradient.
//
//  channel | ports                          | beat contents
//  --------+--------------------------------+------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata   | position, amplitude, center, width
//  result  | out_tvalid/out_tready/out_tdata| value, grad_amplitude, grad_center, grad_width
//
// One beat is taken every clock unless the pipeline holds; the latency is set by the two
// bit-per-stage dividers (25 stages for xl, 33 for the gradient scaling), plus the shape
// unit and the multiplier stages.
// rst_n is synchronous and clears only the valid bits of every stage.
// The whole pipeline, input included, holds while a result waits and out_tready is low;
// nothing is dropped or repeated, and a beat is taken in every cycle without such a hold.
module gaussian_line_with_gradient #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] position, [63:32] amplitude, [95:64] center, [127:96] width
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] value, [48:32] grad_amplitude, [80:49] grad_center, [112:81] grad_width
  output logic [119:0] out_tdata
);
  import glg_pkg::*;

  localparam int SHL     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int NUM2_W  = 57 + SHL;
  localparam int DEN2_W  = 31 + SHR;
  localparam int SIDE_W  = $bits(glg_side_t);
  localparam int CSIDE_W = 32 + 17 + 2;

  logic en;
  logic out_valid_r;
  logic [31:0] value_r, gc_r, gw_r;
  logic [16:0] ga_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 0: input register and x - center.
  logic               v0_r;
  logic signed [32:0] d0_r;
  logic signed [31:0] amp0_r, w0_r;

  // Stage 1: magnitudes and width clamp.
  logic        v1_r;
  logic [32:0] ad1_r;
  logic        dneg1_r, aneg1_r;
  logic [31:0] am1_r;
  logic [30:0] w1_r;

  // Stage 2: divider operands for xl.
  logic        v2_r;
  logic [49:0] num2_r;
  glg_side_t   side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r    <= 33'(signed'(in_tdata[31:0])) - 33'(signed'(in_tdata[95:64]));
      amp0_r  <= signed'(in_tdata[63:32]);
      w0_r    <= signed'(in_tdata[127:96]);
      dneg1_r <= d0_r < 0;
      ad1_r   <= (d0_r < 0) ? 33'(-d0_r) : 33'(d0_r);
      aneg1_r <= amp0_r < 0;
      am1_r   <= (amp0_r < 0) ? 32'(-33'(amp0_r)) : 32'(amp0_r);
      w1_r    <= (w0_r <= 0) ? 31'd1 : w0_r[30:0];
      num2_r  <= {ad1_r, 17'd0} + 50'(w1_r >> 1);
      side2_r <= '{amp_mag: am1_r, amp_neg: aneg1_r, dist_neg: dneg1_r, width: w1_r};
    end
  end

  logic              xv;
  logic [23:0]       xlm;
  logic              xovf;
  logic [SIDE_W-1:0] xside;

  glg_div #(.NUM_W(50), .DEN_W(31), .Q_W(24), .SIDE_W(SIDE_W)) u_div_xl (
    .clk, .rst_n, .en,
    .in_valid (v2_r),
    .num      (num2_r),
    .den      (side2_r.width),
    .side_in  (side2_r),
    .out_valid(xv),
    .quot     (xlm),
    .ovf      (xovf),
    .side_out (xside)
  );

  logic              sv;
  logic [16:0]       shape;
  logic [18:0]       xlm_z;
  logic [20:0]       q_z;
  logic [SIDE_W-1:0] sside_raw;
  glg_side_t         sside;

  glg_shape #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH), .SIDE_W(SIDE_W)) u_shape (
    .clk, .rst_n, .en,
    .in_valid (xv),
    .xlm      (xlm),
    .xlm_ovf  (xovf),
    .side_in  (xside),
    .out_valid(sv),
    .shape    (shape),
    .xlm_z    (xlm_z),
    .q_z      (q_z),
    .side_out (sside_raw)
  );

  assign sside = glg_side_t'(sside_raw);

  // Stages 3 to 7: products with the shape, ln2 scaling, rounding and amplitude.
  logic        v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [35:0] p1_3_r;
  logic [37:0] p2_3_r;
  logic [48:0] pv3_r;
  logic [59:0] t1_4_r;
  logic [61:0] t2_4_r;
  logic [31:0] vmag4_r, vmag5_r, vmag6_r, vmag7_r;
  logic [21:0] g1_5_r, g2_5_r;
  logic [53:0] c6_r, wp6_r;
  logic [NUM2_W-1:0] numc7_r, numw7_r;
  logic [DEN2_W-1:0] den7_r;
  logic [16:0] shp3_r, shp4_r, shp5_r, shp6_r, shp7_r;
  glg_side_t   s3_r, s4_r, s5_r, s6_r;
  logic        aneg7_r, dneg7_r;
  logic [DEN2_W-1:0] den6;

  assign den6 = DEN2_W'(s6_r.width) << SHR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v3_r <= sv;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_3_r  <= 36'(shape) * 36'(xlm_z);
      p2_3_r  <= 38'(shape) * 38'(q_z);
      pv3_r   <= 49'(sside.amp_mag) * 49'(shape);
      shp3_r  <= shape;
      s3_r    <= sside;
      t1_4_r  <= 60'(p1_3_r) * 60'(LN2_Q24);
      t2_4_r  <= 62'(p2_3_r) * 62'(LN2_Q24);
      vmag4_r <= 32'((pv3_r + 49'd32768) >> 16);
      shp4_r  <= shp3_r;
      s4_r    <= s3_r;
      g1_5_r  <= 22'((61'(t1_4_r) + (61'd1 << 39)) >> 40);
      g2_5_r  <= 22'((63'(t2_4_r) + (63'd1 << 39)) >> 40);
      vmag5_r <= vmag4_r;
      shp5_r  <= shp4_r;
      s5_r    <= s4_r;
      c6_r    <= 54'(s5_r.amp_mag) * 54'(g1_5_r);
      wp6_r   <= 54'(s5_r.amp_mag) * 54'(g2_5_r);
      vmag6_r <= vmag5_r;
      shp6_r  <= shp5_r;
      s6_r    <= s5_r;
      numc7_r <= (NUM2_W'(c6_r) << (2 + SHL)) + NUM2_W'(den6 >> 1);
      numw7_r <= (NUM2_W'(wp6_r) << (1 + SHL)) + NUM2_W'(den6 >> 1);
      den7_r  <= den6;
      vmag7_r <= vmag6_r;
      shp7_r  <= shp6_r;
      aneg7_r <= s6_r.amp_neg;
      dneg7_r <= s6_r.dist_neg;
    end
  end

  logic               cv, cov, wov;
  logic [31:0]        cq, wq;
  logic [CSIDE_W-1:0] cside;
  logic               wside;

  glg_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .Q_W(32), .SIDE_W(CSIDE_W)) u_div_gc (
    .clk, .rst_n, .en,
    .in_valid (v7_r),
    .num      (numc7_r),
    .den      (den7_r),
    .side_in  ({vmag7_r, shp7_r, aneg7_r, dneg7_r}),
    .out_valid(cv),
    .quot     (cq),
    .ovf      (cov),
    .side_out (cside)
  );

  // Runs in lockstep with the center divider; its valid matches and is not needed.
  glg_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .Q_W(32), .SIDE_W(1)) u_div_gw (
    .clk, .rst_n, .en,
    .in_valid (v7_r),
    .num      (numw7_r),
    .den      (den7_r),
    .side_in  (aneg7_r),
    .out_valid(),
    .quot     (wq),
    .ovf      (wov),
    .side_out (wside)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= sat32(cside[1], 1'b0, cside[50:19]);
      ga_r    <= cside[18:2];
      gc_r    <= sat32(cside[1] ^ cside[0], cov, cq);
      gw_r    <= sat32(wside, wov, wq);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, gw_r, gc_r, ga_r, value_r};

endmodule
